@@ rtl/core/ismt_pkg.sv @@
// Shared types and constants for the integer set membership table.
`timescale 1ns / 1ps
`default_nettype none
package ismt_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] item_value;
    } in_item_t;

    typedef struct packed {
        logic       was_present;
        logic [4:0] element_count;
        logic       add_dropped;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic capture;
        logic compare;
        logic update;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/core/ismt_ctrl.sv @@
// Request sequencer: capture, parallel compare, then set update and result.
`timescale 1ns / 1ps
`default_nettype none
module ismt_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ismt_pkg::dp_status_t status,
    output ismt_pkg::dp_cmd_t        cmd
);
    import ismt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MATCH;
                end
            end
            ST_MATCH: begin
                cmd.compare = 1'b1;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE: begin
                // hold until the result register can take a new transaction
                if (status.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/ismt_dp.sv @@
// Slot storage, parallel match, slot allocation, count and result register.
`timescale 1ns / 1ps
`default_nettype none
module ismt_dp #(
    parameter int CAPACITY = ismt_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ismt_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ismt_pkg::out_item_t      m_data,
    input  wire ismt_pkg::dp_cmd_t   cmd,
    output ismt_pkg::dp_status_t     status
);
    import ismt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [1:0]          req_reg;
    logic [31:0]         val_reg;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] free_reg;
    logic [31:0]         slot_value_reg [CAPACITY];
    logic [CAPACITY-1:0] slot_valid_reg;
    logic [CAPACITY-1:0] slot_valid_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    out_item_t           m_data_reg;

    logic [CAPACITY-1:0] match_next;
    logic [CAPACITY-1:0] free_onehot;
    logic [31:0]         count_wide;
    logic                present;
    logic                full;
    logic                do_add;
    logic                do_rem;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match_next[i] = slot_valid_reg[i] && (slot_value_reg[i] == val_reg);
        end
    end

    // lowest free slot as a one-hot vector
    assign free_onehot = free_reg & (~free_reg + {{(CAPACITY-1){1'b0}}, 1'b1});
    assign present     = |match_reg;
    assign full        = ~|free_reg;
    assign do_add      = (req_reg == REQ_ADD) && !present && !full;
    assign do_rem      = (req_reg == REQ_REMOVE) && present;

    always_comb begin
        slot_valid_next = slot_valid_reg;
        count_next      = count_reg;
        if (do_add) begin
            slot_valid_next = slot_valid_reg | free_onehot;
            count_next      = count_reg + CW'(1);
        end else if (do_rem) begin
            // values are unique, so at most one match bit is set
            slot_valid_next = slot_valid_reg & ~match_reg;
            count_next      = count_reg - CW'(1);
        end
    end

    assign count_wide = 32'(count_next);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.update) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cmd.update) begin
                slot_valid_reg <= slot_valid_next;
                count_reg      <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data.req_type;
            val_reg <= s_data.item_value;
        end
        if (cmd.compare) begin
            match_reg <= match_next;
            free_reg  <= ~slot_valid_reg;
        end
        if (cmd.update) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (do_add && free_onehot[i]) begin
                    slot_value_reg[i] <= val_reg;
                end
            end
            m_data_reg.was_present   <= present;
            m_data_reg.element_count <= count_wide[4:0];
            m_data_reg.add_dropped   <= (req_reg == REQ_ADD) && !present && full;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;

endmodule
`default_nettype wire

@@ rtl/core/integer_set_membership_table.sv @@
// Integer set membership table: add, remove and query over a small CAM of slots.
// Sequence: the accepted request is captured, all slots are compared in parallel,
// then slots, count and result are updated, stalling while a result is unaccepted.
// A new request is taken only after the update of the previous one, as set by the
// capture/compare/update sequence; it is taken while the previous result still waits on m_ready.
// Reset (aresetn low, synchronous): all slots invalid, count zero, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module integer_set_membership_table #(
    parameter int CAPACITY = ismt_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ismt_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ismt_pkg::out_item_t      m_data
);
    import ismt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ismt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ismt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

endmodule
`default_nettype wire
